// ===== rtl/core/lvns_pkg.sv =====
// shared types and constants for the smoothed lattice value noise block
`timescale 1ns / 1ps
package lvns_pkg;

  typedef logic [31:0]        word_t;
  typedef logic signed [31:0] sword_t;
  typedef logic signed [63:0] wide_t;
  typedef logic signed [35:0] sum_t;
  typedef logic [2:0]         vidx_t;

  localparam int NumSets    = 6;
  localparam int NumLanes   = 9;
  localparam int CenterLane = 4;
  localparam int NumRows    = 3;
  localparam int NumStages  = 11;

  // constant set that hashes x alone
  localparam vidx_t XOnlySet = 3'd5;

  // hash constants per set
  localparam word_t HashA [NumSets] = '{
    32'd14557, 32'd15581, 32'd15683, 32'd15731, 32'd16069, 32'd16253
  };
  localparam word_t HashB [NumSets] = '{
    32'd788913, 32'd788947, 32'd789137, 32'd789221, 32'd789533, 32'd789721
  };
  localparam word_t HashC [NumSets] = '{
    32'd1376312323, 32'd1376312543, 32'd1376312783,
    32'd1376312589, 32'd1377313061, 32'd1377313391
  };
  localparam word_t HashD [NumSets] = '{
    32'd1073741827, 32'd1073741789, 32'd1073741971,
    32'd1073741824, 32'd1073842787, 32'd1073843167
  };

  // reciprocal of each divisor, round(2^61 / D), all below 2^32
  localparam logic [63:0] Two61 = 64'h2000_0000_0000_0000;
  localparam logic [32:0] HashM [NumSets] = '{
    33'((Two61 + 64'(HashD[0] / 2)) / 64'(HashD[0])),
    33'((Two61 + 64'(HashD[1] / 2)) / 64'(HashD[1])),
    33'((Two61 + 64'(HashD[2] / 2)) / 64'(HashD[2])),
    33'((Two61 + 64'(HashD[3] / 2)) / 64'(HashD[3])),
    33'((Two61 + 64'(HashD[4] / 2)) / 64'(HashD[4])),
    33'((Two61 + 64'(HashD[5] / 2)) / 64'(HashD[5]))
  };

  // neighbor offsets on the hash input, row major from (x-1, y-1)
  localparam word_t LaneOffXy [NumLanes] = '{
    word_t'(-32'sd58), word_t'(-32'sd57), word_t'(-32'sd56),
    word_t'(-32'sd1),  32'd0,             32'd1,
    32'd56,            32'd57,            32'd58
  };
  localparam word_t LaneOffX [NumLanes] = '{
    word_t'(-32'sd1), 32'd0, 32'd1,
    word_t'(-32'sd1), 32'd0, 32'd1,
    word_t'(-32'sd1), 32'd0, 32'd1
  };

  // weight as a left shift: corner 1, side 2, center 4
  localparam logic [1:0] LaneShift [NumLanes] = '{
    2'd0, 2'd1, 2'd0,
    2'd1, 2'd2, 2'd1,
    2'd0, 2'd1, 2'd0
  };

  // per-request control that rides along the pipeline
  typedef struct packed {
    logic  smooth;
    logic  bad;
    vidx_t vidx;
  } ctl_t;

endpackage

// ===== rtl/core/lvns_if.sv =====
// valid/ready channels for requests and results of the noise block
`timescale 1ns / 1ps
interface lvns_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_coord;
  logic [31:0] y_coord;
  logic [2:0]  variant;
  logic        mode;

  modport source (output valid, x_coord, y_coord, variant, mode, input ready);
  modport sink   (input valid, x_coord, y_coord, variant, mode, output ready);
endinterface

interface lvns_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] noise_value;
  logic        bad_variant;

  modport source (output valid, noise_value, bad_variant, input ready);
  modport sink   (input valid, noise_value, bad_variant, output ready);
endinterface

// ===== rtl/core/lattice_value_noise_smoothed_top.sv =====
// top level of the smoothed lattice value noise pipeline
//
// usage
//   in_i  : request channel, a lattice point (x_coord, y_coord), a hash
//           variant and a mode (0 raw point value, 1 smoothed 3x3 value)
//   out_o : result channel, noise_value in signed Q1.30 and bad_variant
//   a variant of NUM_VARIANTS or more returns bad_variant = 1, value 0
// timing
//   eleven register stages; the result is held in the last one and one
//   request per cycle is sustained while out_o.ready stays high. nine hash
//   lanes run side by side, each with three truncated
//   32x32 multiplies, a reciprocal multiply and a back multiply that settle
//   the rounded quotient
// reset
//   rst_ni clears every stage valid bit; no result is shown after reset
// back pressure
//   each stage holds its item while the stage after it is full and
//   stalled, so empty stages keep filling; in_i.ready drops only once
//   every stage holds an item and out_o.ready is low
`timescale 1ns / 1ps
module lattice_value_noise_smoothed_top #(
  parameter int NUM_VARIANTS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lvns_in_if.sink    in_i,
  lvns_out_if.source out_o
);
  import lvns_pkg::*;

  // stage valid bits and advance enables
  logic [NumStages:1]   vld_q;
  logic [NumStages+1:1] en;
  ctl_t                 ctl_q [NumStages-1];
  ctl_t                 ctl_in;

  // stage 1
  word_t  base_q;
  word_t  base_d;
  // stage 2
  word_t  nx2_q [NumLanes];
  word_t  nx2_d [NumLanes];
  // stage 3
  word_t  sq3_q [NumLanes];
  word_t  nx3_q [NumLanes];
  word_t  sq3_d [NumLanes];
  // stage 4
  word_t  p4_q  [NumLanes];
  word_t  nx4_q [NumLanes];
  word_t  p4_d  [NumLanes];
  // stage 5
  word_t  h5_q  [NumLanes];
  word_t  h5_d  [NumLanes];
  // stage 6
  wide_t  pr6_q [NumLanes];
  sword_t t6_q  [NumLanes];
  wide_t  pr6_d [NumLanes];
  sword_t t6_d  [NumLanes];
  // stage 7
  sword_t e7_q  [NumLanes];
  sword_t t7_q  [NumLanes];
  sword_t e7_d  [NumLanes];
  // stage 8
  wide_t  qd8_q [NumLanes];
  sword_t e8_q  [NumLanes];
  sword_t t8_q  [NumLanes];
  wide_t  qd8_d [NumLanes];
  // stage 9
  sword_t val9_q [NumLanes];
  sword_t val9_d [NumLanes];
  // stage 10
  sum_t   row10_q [NumRows];
  sword_t raw10_q;
  sum_t   row10_d [NumRows];
  // stage 11
  word_t  res11_q;
  logic   bad11_q;
  word_t  res11_d;
  sum_t   total;

  // stall chain: a stage moves when empty or when its successor moves
  always_comb begin
    en[NumStages+1] = out_o.ready;
    for (int s = NumStages; s >= 1; s--) begin
      en[s] = ~vld_q[s] | en[s+1];
    end
  end

  assign in_i.ready = en[1];

  // request control
  always_comb begin
    ctl_in.smooth = in_i.mode;
    ctl_in.bad    = (in_i.variant >= 3'(NUM_VARIANTS));
    ctl_in.vidx   = ctl_in.bad ? '0 : in_i.variant;
  end

  // valid bits and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= in_i.valid;
      for (int s = 2; s <= NumStages; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) ctl_q[0] <= ctl_in;
    for (int s = 1; s < NumStages - 1; s++) begin
      if (en[s+1]) ctl_q[s] <= ctl_q[s-1];
    end
  end

  // stage 1: common hash input, x + 57y or x alone
  assign base_d = (ctl_in.vidx == XOnlySet) ? in_i.x_coord
                                            : in_i.x_coord + in_i.y_coord * 32'd57;

  // stage 2 to 9 lane logic, one column per neighbor
  always_comb begin
    word_t       nsum;
    sword_t      e;
    wide_t       rnd;
    wide_t       num;
    wide_t       rem;
    wide_t       two_d;
    logic [32:0] tdiff;
    for (int k = 0; k < NumLanes; k++) begin
      // stage 2: neighbor input and xor shift
      nsum     = base_q + ((ctl_q[0].vidx == XOnlySet) ? LaneOffX[k] : LaneOffXy[k]);
      nx2_d[k] = nsum ^ (nsum << 13);
      // stage 3: square
      sq3_d[k] = nx2_q[k] * nx2_q[k];
      // stage 4: times a plus b
      p4_d[k]  = sq3_q[k] * HashA[ctl_q[2].vidx] + HashB[ctl_q[2].vidx];
      // stage 5: times n plus c
      h5_d[k]  = nx4_q[k] * p4_q[k] + HashC[ctl_q[3].vidx];
      // stage 6: t = d - m, then t times reciprocal
      tdiff    = {1'b0, HashD[ctl_q[4].vidx]} - {2'b00, h5_q[k][30:0]};
      t6_d[k]  = sword_t'(tdiff[31:0]);
      pr6_d[k] = wide_t'(t6_d[k]) * wide_t'($signed({31'b0, HashM[ctl_q[4].vidx]}));
      // stage 7: rounded estimate of t * 2^30 / d
      rnd      = pr6_q[k] + (64'sd1 <<< 30);
      e7_d[k]  = sword_t'(rnd[62:31]);
      // stage 8: back multiply by 2d
      two_d    = $signed({32'b0, HashD[ctl_q[6].vidx][30:0], 1'b0});
      qd8_d[k] = wide_t'(e7_q[k]) * two_d;
      // stage 9: remainder check, estimate is within one of the result
      two_d    = $signed({32'b0, HashD[ctl_q[7].vidx][30:0], 1'b0});
      num      = $signed({t8_q[k][31], t8_q[k], HashD[ctl_q[7].vidx][30:0]});
      rem      = num - qd8_q[k];
      e        = e8_q[k];
      if (rem[63]) begin
        val9_d[k] = e - 32'sd1;
      end else if (rem >= two_d) begin
        val9_d[k] = e + 32'sd1;
      end else begin
        val9_d[k] = e;
      end
    end
  end

  // stage 10: weighted row sums
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      row10_d[r] = '0;
      for (int c = 0; c < 3; c++) begin
        row10_d[r] = row10_d[r] + (sum_t'(val9_q[3*r+c]) <<< LaneShift[3*r+c]);
      end
    end
  end

  // stage 11: total, floor divide by 16 and select the result
  always_comb begin
    total = row10_q[0] + row10_q[1] + row10_q[2];
    if (ctl_q[9].bad) begin
      res11_d = '0;
    end else if (ctl_q[9].smooth) begin
      res11_d = word_t'(total[35:4]);
    end else begin
      res11_d = word_t'(raw10_q);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en[1]) base_q <= base_d;
    for (int k = 0; k < NumLanes; k++) begin
      if (en[2]) nx2_q[k] <= nx2_d[k];
      if (en[3]) begin
        sq3_q[k] <= sq3_d[k];
        nx3_q[k] <= nx2_q[k];
      end
      if (en[4]) begin
        p4_q[k]  <= p4_d[k];
        nx4_q[k] <= nx3_q[k];
      end
      if (en[5]) h5_q[k] <= h5_d[k];
      if (en[6]) begin
        pr6_q[k] <= pr6_d[k];
        t6_q[k]  <= t6_d[k];
      end
      if (en[7]) begin
        e7_q[k] <= e7_d[k];
        t7_q[k] <= t6_q[k];
      end
      if (en[8]) begin
        qd8_q[k] <= qd8_d[k];
        e8_q[k]  <= e7_q[k];
        t8_q[k]  <= t7_q[k];
      end
      if (en[9]) val9_q[k] <= val9_d[k];
    end
    if (en[10]) begin
      for (int r = 0; r < NumRows; r++) begin
        row10_q[r] <= row10_d[r];
      end
      raw10_q <= val9_q[CenterLane];
    end
    if (en[11]) begin
      res11_q <= res11_d;
      bad11_q <= ctl_q[9].bad;
    end
  end

  assign out_o.valid       = vld_q[NumStages];
  assign out_o.noise_value = res11_q;
  assign out_o.bad_variant = bad11_q;

endmodule

// ===== rtl/core/lvns_checker.sv =====
// port level checks for the noise block, bound to the top level
`timescale 1ns / 1ps
module lvns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] noise_value_i,
  input logic        bad_variant_i
);

  // a rejected variant always carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_variant_i |-> noise_value_i == 32'd0)
    else $error("bad variant with nonzero value");

  // a good value never exceeds +1.0 in Q1.30
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !bad_variant_i |-> $signed(noise_value_i) <= 32'sh4000_0000)
    else $error("noise value above +1.0");

  // no result right after reset is released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(noise_value_i)
      && $stable(bad_variant_i))
    else $error("stalled result changed");

endmodule

bind lattice_value_noise_smoothed_top lvns_checker u_lvns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .noise_value_i (out_o.noise_value),
  .bad_variant_i (out_o.bad_variant)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the smoothed lattice value noise block
`timescale 1ns / 1ps
module testbench;
  import lvns_pkg::*;

  localparam int          NUM_SETS    = 6;
  localparam int          LONG_HOLD   = 250;
  localparam int          RAND_ITEMS  = 1500;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          MAX_REPORTS = 10;
  localparam logic        MODE_RAW    = 1'b0;
  localparam logic        MODE_SMOOTH = 1'b1;
  localparam logic [2:0]  VAR_X_ONLY  = 3'd5;
  localparam logic [2:0]  VAR_BAD_LO  = 3'd6;
  localparam logic [2:0]  VAR_BAD_HI  = 3'd7;

  // hash constant sets, one column per variant
  localparam logic [31:0] SET_A [NUM_SETS] = '{
    32'd14557, 32'd15581, 32'd15683, 32'd15731, 32'd16069, 32'd16253
  };
  localparam logic [31:0] SET_B [NUM_SETS] = '{
    32'd788913, 32'd788947, 32'd789137, 32'd789221, 32'd789533, 32'd789721
  };
  localparam logic [31:0] SET_C [NUM_SETS] = '{
    32'd1376312323, 32'd1376312543, 32'd1376312783,
    32'd1376312589, 32'd1377313061, 32'd1377313391
  };
  localparam longint SET_D [NUM_SETS] = '{
    64'sd1073741827, 64'sd1073741789, 64'sd1073741971,
    64'sd1073741824, 64'sd1073842787, 64'sd1073843167
  };

  // one request, with a typed-in result where it is obvious
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [2:0]  variant;
    logic        mode;
    logic        known;
    logic [31:0] known_value;
    logic        known_bad;
  } noise_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        bad;
  } noise_res_t;

  localparam int DIR_ROWS = 20;

  // directed requests: extremes, both modes, every variant, bad variants
  localparam noise_req_t DIR_TAB [DIR_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 3'd0, MODE_RAW,    1'b0, 32'h0, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 3'd0, MODE_SMOOTH, 1'b0, 32'h0, 1'b0},
    '{32'h7fff_ffff, 32'h7fff_ffff, 3'd1, MODE_RAW,    1'b0, 32'h0, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 3'd2, MODE_SMOOTH, 1'b0, 32'h0, 1'b0},
    '{32'hffff_ffff, 32'hffff_ffff, 3'd3, MODE_RAW,    1'b0, 32'h0, 1'b0},
    '{32'hffff_ffff, 32'h0000_0000, 3'd3, MODE_SMOOTH, 1'b0, 32'h0, 1'b0},
    '{32'h7fff_ffff, 32'h8000_0000, 3'd4, MODE_SMOOTH, 1'b0, 32'h0, 1'b0},
    '{32'h8000_0000, 32'h7fff_ffff, 3'd4, MODE_RAW,    1'b0, 32'h0, 1'b0},
    '{32'h0001_2345, 32'h0000_dead, VAR_X_ONLY, MODE_RAW, 1'b0, 32'h0, 1'b0},
    '{32'h0001_2345, 32'h0000_beef, VAR_X_ONLY, MODE_RAW, 1'b0, 32'h0, 1'b0},
    '{32'h7fff_ffff, 32'h0000_0000, VAR_X_ONLY, MODE_SMOOTH, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0001, 32'hffff_ffff, 3'd1, MODE_SMOOTH, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, VAR_BAD_LO, MODE_RAW,    1'b1, 32'h0, 1'b1},
    '{32'h1234_5678, 32'h9abc_def0, VAR_BAD_HI, MODE_SMOOTH, 1'b1, 32'h0, 1'b1},
    '{32'hffff_ffff, 32'hffff_ffff, VAR_BAD_LO, MODE_SMOOTH, 1'b1, 32'h0, 1'b1},
    '{32'h8000_0000, 32'h7fff_ffff, VAR_BAD_HI, MODE_RAW,    1'b1, 32'h0, 1'b1},
    '{32'haaaa_aaaa, 32'h5555_5555, 3'd2, MODE_RAW,    1'b0, 32'h0, 1'b0},
    '{32'h5555_5555, 32'haaaa_aaaa, 3'd0, MODE_SMOOTH, 1'b0, 32'h0, 1'b0},
    '{32'hffff_ffc7, 32'h0000_0001, 3'd3, MODE_RAW,    1'b0, 32'h0, 1'b0},
    '{32'h0000_0000, 32'hffff_ffff, VAR_X_ONLY, MODE_SMOOTH, 1'b0, 32'h0, 1'b0}
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  lvns_in_if  req_if ();
  lvns_out_if res_if ();

  noise_res_t pending_noise [$];
  int         mismatch_cnt = 0;

  lattice_value_noise_smoothed_top #(
    .NUM_VARIANTS(NUM_SETS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // floor division for a positive divisor
  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // value of one lattice point in q1.30, rounded to nearest with ties up
  function automatic longint lattice_q30(input logic [31:0] x, input logic [31:0] y,
                                         input int set);
    logic [31:0] n;
    logic [31:0] h;
    longint      frac;
    longint      num;
    n = (set == int'(VAR_X_ONLY)) ? x : x + 32'd57 * y;
    n = n ^ (n << 13);
    h = n * (n * n * SET_A[set] + SET_B[set]) + SET_C[set];
    frac = longint'({33'd0, h[30:0]});
    num = (SET_D[set] - frac) * (64'sd1 <<< 30);
    return floor_quot(2 * num + SET_D[set], 2 * SET_D[set]);
  endfunction

  // expected result of one request
  function automatic noise_res_t noise_q30(input noise_req_t r);
    noise_res_t res;
    longint     acc;
    longint     wgt;
    res = '0;
    if (int'(r.variant) >= NUM_SETS) begin
      res.bad = 1'b1;
      return res;
    end
    if (r.mode == MODE_RAW) begin
      acc = lattice_q30(r.x, r.y, int'(r.variant));
    end else begin
      acc = 0;
      // 3x3 neighborhood, corner 1, side 2, center 4, then divide by 16
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          wgt = ((dx == 0) ? 2 : 1) * ((dy == 0) ? 2 : 1);
          acc += wgt * lattice_q30(r.x + 32'(dx), r.y + 32'(dy), int'(r.variant));
        end
      end
      acc = acc >>> 4;
    end
    res.value = acc[31:0];
    return res;
  endfunction

  // random request: mostly full range, some near the origin or the wrap points
  function automatic noise_req_t random_request();
    noise_req_t       r;
    int               pick;
    logic [31:0]      edges [4];
    edges = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000};
    r = '0;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      r.x = $urandom;
      r.y = $urandom;
    end else if (pick < 8) begin
      r.x = 32'($urandom_range(0, 127)) - 32'd64;
      r.y = 32'($urandom_range(0, 127)) - 32'd64;
    end else begin
      r.x = edges[$urandom_range(0, 3)] + 32'($urandom_range(0, 2)) - 32'd1;
      r.y = edges[$urandom_range(0, 3)] + 32'($urandom_range(0, 2)) - 32'd1;
    end
    if ($urandom_range(0, 11) == 0) r.variant = 3'($urandom_range(6, 7));
    else r.variant = 3'($urandom_range(0, NUM_SETS - 1));
    r.mode = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  // compare one result with the oldest expectation
  task automatic check_result(input logic [31:0] value, input logic bad);
    noise_res_t want;
    if (pending_noise.size() == 0) begin
      if (mismatch_cnt < MAX_REPORTS)
        $display("result with no request pending: value %h bad %b", value, bad);
      mismatch_cnt++;
    end else begin
      want = pending_noise.pop_front();
      if (value !== want.value || bad !== want.bad) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("noise mismatch: expected value %h bad %b, got value %h bad %b",
                   want.value, want.bad, value, bad);
        mismatch_cnt++;
      end
    end
  endtask

  // result side: random stalls, two long hold-offs to back up the pipeline
  initial begin
    int  stall;
    int  seen;
    bit  steady;
    res_if.ready = 1'b0;
    stall  = 0;
    seen   = 0;
    steady = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        check_result(res_if.noise_value, res_if.bad_variant);
        seen++;
        if (seen % 64 == 0) steady = ($urandom_range(0, 2) == 0);
        if (seen == 150 || seen == 900) stall = LONG_HOLD;
        else stall = draw_gap(steady);
      end
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // request side: directed table, then random requests
  initial begin
    noise_req_t reqs [$];
    noise_req_t r;
    noise_res_t want;
    int         gap;
    int         pause_a;
    int         pause_b;
    bit         steady;
    req_if.valid   = 1'b0;
    req_if.x_coord = '0;
    req_if.y_coord = '0;
    req_if.variant = '0;
    req_if.mode    = MODE_RAW;
    for (int i = 0; i < DIR_ROWS; i++) reqs.push_back(DIR_TAB[i]);
    for (int i = 0; i < RAND_ITEMS; i++) reqs.push_back(random_request());
    pause_a = DIR_ROWS;
    pause_b = DIR_ROWS + RAND_ITEMS / 2;
    steady  = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    gap = draw_gap(steady);
    for (int idx = 0; idx < reqs.size(); idx++) begin
      r = reqs[idx];
      // sender holds off until the pipeline has drained
      if (idx == pause_a || idx == pause_b) begin
        while (pending_noise.size() != 0) @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
      req_if.valid   <= 1'b1;
      req_if.x_coord <= r.x;
      req_if.y_coord <= r.y;
      req_if.variant <= r.variant;
      req_if.mode    <= r.mode;
      do @(posedge clk_i); while (!req_if.ready);
      if (r.known) begin
        want.value = r.known_value;
        want.bad   = r.known_bad;
      end else begin
        want = noise_q30(r);
      end
      pending_noise.push_back(want);
      if (idx % 64 == 0) steady = ($urandom_range(0, 2) == 0);
      gap = draw_gap(steady);
      if (gap != 0 || idx + 1 == reqs.size() || idx + 1 == pause_a || idx + 1 == pause_b)
        req_if.valid <= 1'b0;
    end
    while (pending_noise.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_noise.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lvns_pkg.sv
rtl/core/lvns_if.sv
rtl/core/lattice_value_noise_smoothed_top.sv
rtl/core/lvns_checker.sv
tb/testbench.sv
